@@ hw/rtl/jpeg_coefficient_run_decoder_defines.svh @@
// ----------------------------------------------------------------------------
// JPEG coefficient run decoder: assertion macros
// Concurrent check wrappers, clocked on clk and quiet while rst is high.
// ----------------------------------------------------------------------------
`ifndef JPEG_COEFFICIENT_RUN_DECODER_DEFINES_SVH
`define JPEG_COEFFICIENT_RUN_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF
// expression must hold at every clock edge
`define JCRD_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// antecedent in this cycle implies consequent in the next
`define JCRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define JCRD_ASSERT(lbl, expr, msg)
`define JCRD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ hw/rtl/jcrd_pkg.sv @@
// ----------------------------------------------------------------------------
// jcrd_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package jcrd_pkg;

  localparam int DEF_BLOCK_COEFFS   = 64;
  localparam int DEF_NUM_COMPONENTS = 4;

  localparam int IN_TDATA_W  = 24;  // symbol + magnitude bits, byte padded
  localparam int IN_TUSER_W  = 2;   // component
  localparam int OUT_TDATA_W = 32;  // coefficient + position + block_done
  localparam int COEF_W      = 21;
  localparam int EXT_W       = 16;
  localparam int POS_OUT_W   = 6;

  localparam logic [7:0] SYM_ZRL = 8'hF0;
  localparam logic [7:0] SYM_EOB = 8'h00;
  localparam logic [3:0] NIBBLE  = 4'hF;
  localparam int         ZRL_LEN = 16;

  localparam logic signed [COEF_W:0] COEF_MAX = 22'sd1048575;
  localparam logic signed [COEF_W:0] COEF_MIN = -22'sd1048576;

  typedef struct packed {
    logic load;  // latch a new request
    logic emit;  // produce one result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;      // next result is the last one of this request
    logic out_free;  // output register can take a result this cycle
  } dp_status_t;

endpackage

@@ hw/rtl/jcrd_ctrl.sv @@
// ----------------------------------------------------------------------------
// jcrd_ctrl
// Request sequencer: takes one request, then issues one emit per free slot.
// ----------------------------------------------------------------------------
`include "jpeg_coefficient_run_decoder_defines.svh"

module jcrd_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  jcrd_pkg::dp_status_t   status,
  output jcrd_pkg::ctrl_cmd_t    cmd
);
  import jcrd_pkg::*;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t state;

  assign s_tready = (state == ST_IDLE);
  assign cmd.load = s_tvalid && s_tready;
  assign cmd.emit = (state == ST_RUN) && status.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.load) state <= ST_RUN;
        end
        ST_RUN: begin
          if (cmd.emit && status.last) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `JCRD_ASSERT_NEXT(a_load_runs, cmd.load, state == ST_RUN, "load did not start a run")
  `JCRD_ASSERT_NEXT(a_last_ends, cmd.emit && status.last, state == ST_IDLE, "run did not end")
  `JCRD_ASSERT(a_emit_in_run, !cmd.emit || !cmd.load, "emit and load in one cycle")

endmodule

@@ hw/rtl/jcrd_datapath.sv @@
// ----------------------------------------------------------------------------
// jcrd_datapath
// Position counter, DC predictors, value extension and output register.
// ----------------------------------------------------------------------------
`include "jpeg_coefficient_run_decoder_defines.svh"

module jcrd_datapath #(
  parameter int BLOCK_COEFFS   = jcrd_pkg::DEF_BLOCK_COEFFS,
  parameter int NUM_COMPONENTS = jcrd_pkg::DEF_NUM_COMPONENTS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  jcrd_pkg::ctrl_cmd_t                    cmd,
  output jcrd_pkg::dp_status_t                   status,
  input  logic [1:0]                             component,
  input  logic [7:0]                             symbol,
  input  logic [14:0]                            magnitude_bits,
  input  logic                                   out_ready,
  output logic                                   out_valid,
  output logic signed [jcrd_pkg::COEF_W-1:0]     coefficient,
  output logic [jcrd_pkg::POS_OUT_W-1:0]         position,
  output logic                                   block_done,
  output logic                                   run_last,
  output logic                                   bad_symbol
);
  import jcrd_pkg::*;

  localparam int POS_W = $clog2(BLOCK_COEFFS);
  localparam int CMP_W = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;
  localparam logic [POS_W:0]   BLOCK_LEN = (POS_W+1)'(BLOCK_COEFFS);
  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(BLOCK_COEFFS - 1);

  // machine state
  logic [POS_W-1:0]         pos;
  logic signed [COEF_W-1:0] pred [NUM_COMPONENTS];

  // latched request
  logic                     item_dc;
  logic                     item_bad;
  logic                     item_val;
  logic [POS_W-1:0]         cnt_left;
  logic [CMP_W-1:0]         comp_idx;
  logic signed [EXT_W-1:0]  ext_val;

  // load-side decode
  logic [3:0]               cls;
  logic [15:0]              mask16;
  logic [14:0]              v;
  logic                     neg;
  logic signed [EXT_W-1:0]  ext_next;
  logic [POS_W:0]           remaining;
  logic [POS_W:0]           zeros;
  logic [POS_W:0]           total;
  logic                     has_val;
  logic                     bad_ac;
  logic [POS_W:0]           count;
  logic [2:0]               comp3;
  logic [CMP_W-1:0]         comp_fold;

  // run-side
  logic signed [COEF_W:0]   sum;
  logic signed [COEF_W-1:0] sat;
  logic                     last;
  logic signed [COEF_W-1:0] ac_coef;

  always_comb begin
    if (pos == '0 && symbol[7:4] != 4'd0) cls = 4'd0;
    else cls = symbol[3:0] & NIBBLE;
    mask16   = (16'd1 << cls) - 16'd1;
    v        = magnitude_bits & mask16[14:0];
    neg      = (cls != 4'd0) && !v[cls - 4'd1];
    ext_next = neg ? ($signed({1'b0, v}) - $signed({1'b0, mask16[14:0]}))
                   : $signed({1'b0, v});

    remaining = BLOCK_LEN - {1'b0, pos};
    has_val   = 1'b1;
    if (symbol == SYM_ZRL) begin
      zeros   = (POS_W+1)'(ZRL_LEN);
      has_val = 1'b0;
    end else if (symbol == SYM_EOB) begin
      zeros   = remaining;
      has_val = 1'b0;
    end else begin
      zeros = (POS_W+1)'(symbol[7:4]);
    end
    total  = zeros + (POS_W+1)'(has_val);
    bad_ac = total > remaining;
    count  = bad_ac ? remaining : total;

    comp3 = {1'b0, component};
    if (NUM_COMPONENTS == 1) comp3 = 3'd0;
    else if (comp3 >= 3'(NUM_COMPONENTS)) comp3 = comp3 - 3'(NUM_COMPONENTS);
    comp_fold = CMP_W'(comp3);
  end

  always_comb begin
    sum = $signed({pred[comp_idx][COEF_W-1], pred[comp_idx]})
        + (COEF_W+1)'(ext_val);
    if (sum > COEF_MAX) sat = COEF_MAX[COEF_W-1:0];
    else if (sum < COEF_MIN) sat = COEF_MIN[COEF_W-1:0];
    else sat = sum[COEF_W-1:0];

    last = item_dc || (cnt_left == POS_W'(1));
    // a value only lands when the run fits; an overrun is cut before it
    ac_coef = (item_val && !item_bad && last) ? COEF_W'(ext_val) : '0;
  end

  assign status.last     = last;
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_COMPONENTS; i++) pred[i] <= '0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (item_dc) begin
          pred[comp_idx] <= sat;
          pos            <= POS_W'(1);
        end else if (pos == LAST_POS) begin
          pos <= '0;
        end else begin
          pos <= pos + POS_W'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_dc  <= (pos == '0);
      item_bad <= (pos == '0) ? (symbol[7:4] != 4'd0) : bad_ac;
      item_val <= has_val;
      cnt_left <= (pos == '0) ? POS_W'(1) : count[POS_W-1:0];
      comp_idx <= comp_fold;
      ext_val  <= ext_next;
    end else if (cmd.emit) begin
      cnt_left <= cnt_left - POS_W'(1);
    end
    if (cmd.emit) begin
      coefficient <= item_dc ? sat : ac_coef;
      position    <= item_dc ? '0 : POS_OUT_W'(pos);
      block_done  <= !item_dc && (pos == LAST_POS);
      run_last    <= last;
      bad_symbol  <= item_bad;
    end
  end

  `JCRD_ASSERT(a_pos_range, {1'b0, pos} < BLOCK_LEN, "position left the block")
  `JCRD_ASSERT_NEXT(a_dc_step, cmd.emit && item_dc, pos == POS_W'(1), "DC did not advance")
  `JCRD_ASSERT(a_bad_end, !(out_valid && run_last && bad_symbol && position != '0) || block_done, "overrun not cut at block end")

endmodule

@@ hw/rtl/jpeg_coefficient_run_decoder.sv @@
// ----------------------------------------------------------------------------
// jpeg_coefficient_run_decoder
// Baseline JPEG run-length coefficient expansion with DC prediction.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one request per Huffman-decoded symbol: symbol and its
//   appended magnitude bits in s_tdata, component number in s_tuser.
//   Master side delivers one coefficient per beat with its zigzag position
//   and block_done in m_tdata, bad_symbol in m_tuser; m_tlast marks the last
//   coefficient produced by a request.
//   Position 0 of a block takes a DC class; the sign-extended difference is
//   added to the component's predictor (saturating) and stored back.
//   Other positions take AC run/size: ZRL gives 16 zeros, EOB fills the
//   rest of the block, overruns are cut at the block end and flagged.
// Timing:
//   A request is accepted in ST_IDLE; the sequencer then enters ST_RUN and
//   emits one coefficient per cycle into the output register while that
//   register is free. The first result passes the ST_RUN state register
//   and then the output register. No new request is taken in ST_RUN.
//   A stalled receiver freezes the emit sequence; s_tready rises again as
//   soon as the last result is in the output register, even if not taken.
// Reset:
//   rst clears the block position and all DC predictors to zero and drops
//   m_tvalid.
// ----------------------------------------------------------------------------
module jpeg_coefficient_run_decoder #(
  parameter int BLOCK_COEFFS   = jcrd_pkg::DEF_BLOCK_COEFFS,
  parameter int NUM_COMPONENTS = jcrd_pkg::DEF_NUM_COMPONENTS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [7:0] symbol, [22:8] magnitude_bits, [23] zero
  input  logic [jcrd_pkg::IN_TDATA_W-1:0]    s_tdata,
  // [1:0] component
  input  logic [jcrd_pkg::IN_TUSER_W-1:0]    s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [20:0] coefficient, [26:21] position, [27] block_done, [31:28] zero
  output logic [jcrd_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // [0] bad_symbol
  output logic                               m_tuser,
  // run_last
  output logic                               m_tlast
);
  import jcrd_pkg::*;

  ctrl_cmd_t                cmd;
  dp_status_t               status;
  logic signed [COEF_W-1:0] coefficient;
  logic [POS_OUT_W-1:0]     position;
  logic                     block_done;

  // sequencer: one request in flight, emits gated by output register space
  jcrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // decode, predictor update and output register
  jcrd_datapath #(
    .BLOCK_COEFFS   (BLOCK_COEFFS),
    .NUM_COMPONENTS (NUM_COMPONENTS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .component      (s_tuser),
    .symbol         (s_tdata[7:0]),
    .magnitude_bits (s_tdata[22:8]),
    .out_ready      (m_tready),
    .out_valid      (m_tvalid),
    .coefficient    (coefficient),
    .position       (position),
    .block_done     (block_done),
    .run_last       (m_tlast),
    .bad_symbol     (m_tuser)
  );

  assign m_tdata = {4'd0, block_done, position, coefficient};

endmodule

@@ tb/jpeg_coefficient_run_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// jpeg_coefficient_run_decoder_tb
// Streams Huffman-decoded symbols into the run decoder and checks every
// coefficient against an in-bench model of the block position and the
// per-component DC predictors. A short table covers the corner cases, then
// random well-formed blocks (with some junk symbols) run under random stalls
// on both sides, including sweeps that push two predictors into saturation.
// ----------------------------------------------------------------------------
module jpeg_coefficient_run_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jcrd_pkg::*;

  localparam int BLOCK_COEFFS   = DEF_BLOCK_COEFFS;
  localparam int NUM_COMPONENTS = DEF_NUM_COMPONENTS;
  localparam int COEF_HI        = COEF_MAX;
  localparam int COEF_LO        = COEF_MIN;
  localparam int IDLE_PCT       = 23;
  localparam int STALL_LIMIT    = 1000;  // cycles with no request or result moving
  localparam int RANDOM_ITEMS   = 207;
  localparam int PUSH_BLOCKS    = 68;    // DC sweeps, DC then EOB: comp 0 up, comp 1 down
  localparam int N_DIRECTED     = 23;

  // one expected coefficient
  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic [POS_OUT_W-1:0]     pos;
    logic                     done;
    logic                     last;
    logic                     bad;
  } coef_result_t;

  typedef struct {
    logic [1:0]  comp;
    logic [7:0]  sym;
    logic [14:0] mag;
    bit          typed;  // DC row with a hand-written result
    int          coef;
    bit          bad;
  } directed_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [7:0] symbol, [22:8] magnitude_bits, [23] zero
  logic [IN_TUSER_W-1:0]  s_tuser = '0;   // [1:0] component
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // [20:0] coef, [26:21] position, [27] block_done
  logic                   m_tuser;        // [0] bad_symbol
  logic                   m_tlast;        // run_last

  jpeg_coefficient_run_decoder #(
    .BLOCK_COEFFS  (BLOCK_COEFFS),
    .NUM_COMPONENTS(NUM_COMPONENTS)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // model state
  coef_result_t             pending_coefs[$];
  int unsigned              blk_pos = 0;
  logic signed [COEF_W-1:0] dc_pred[NUM_COMPONENTS];

  int unsigned error_count = 0;
  int unsigned stall_cycles = 0;
  bit          quiet = 1'b0;   // no idling on either side while set

  // Corner cases. Typed rows are DC terms whose result is obvious by hand.
  directed_row_t directed_rows[N_DIRECTED] = '{
    '{2'd0, 8'h00,   15'h7FFF, 1'b1, 0,      1'b0},  // class zero, high bits masked
    '{2'd0, SYM_EOB, 15'h0000, 1'b0, 0,      1'b0},  // fill 63 zeros
    '{2'd1, 8'h0F,   15'h7FFF, 1'b1, 32767,  1'b0},  // largest DC step
    '{2'd1, 8'h0F,   15'h7FFF, 1'b0, 0,      1'b0},  // AC size 15
    '{2'd1, 8'h30,   15'h5555, 1'b0, 0,      1'b0},  // size zero, run 3
    '{2'd1, SYM_ZRL, 15'h7FFF, 1'b0, 0,      1'b0},
    '{2'd1, 8'h11,   15'h7FFE, 1'b0, 0,      1'b0},  // masked bits -> -1
    '{2'd2, SYM_ZRL, 15'h0000, 1'b0, 0,      1'b0},
    '{2'd2, SYM_ZRL, 15'h0000, 1'b0, 0,      1'b0},
    '{2'd3, 8'hFF,   15'h7FFF, 1'b0, 0,      1'b0},  // run+value past block end
    '{2'd2, 8'h10,   15'h7FFF, 1'b1, 0,      1'b1},  // DC class above 15
    '{2'd2, SYM_ZRL, 15'h1234, 1'b0, 0,      1'b0},
    '{2'd2, SYM_ZRL, 15'h1234, 1'b0, 0,      1'b0},
    '{2'd2, SYM_ZRL, 15'h1234, 1'b0, 0,      1'b0},
    '{2'd2, SYM_ZRL, 15'h1234, 1'b0, 0,      1'b0},  // ZRL past block end
    '{2'd3, 8'hFF,   15'h2AAA, 1'b1, 0,      1'b1},  // largest bad class
    '{2'd3, SYM_EOB, 15'h7FFF, 1'b0, 0,      1'b0},
    '{2'd3, 8'h01,   15'h0000, 1'b1, -1,     1'b0},
    '{2'd3, 8'hE1,   15'h0001, 1'b0, 0,      1'b0},  // run 14 then +1
    '{2'd0, SYM_EOB, 15'h0000, 1'b0, 0,      1'b0},
    '{2'd0, 8'h0F,   15'h0000, 1'b1, -32767, 1'b0},  // most negative DC step
    '{2'd0, 8'h01,   15'h7FFF, 1'b0, 0,      1'b0},
    '{2'd0, SYM_EOB, 15'h0000, 1'b0, 0,      1'b0}
  };

  // JPEG sign extension of the low 'size' bits
  function automatic int jpeg_extend(logic [14:0] raw, int unsigned size);
    int unsigned v;
    int unsigned half;
    if (size == 0 || size > 15) return 0;
    v    = 32'(raw) & ((32'd1 << size) - 1);
    half = 32'd1 << (size - 1);
    if (v < half) return int'(v) - int'((32'd1 << size) - 1);
    return int'(v);
  endfunction

  // Expand one accepted request into the coefficients it must produce.
  function automatic void decode_request(logic [1:0] comp, logic [7:0] sym,
                                         logic [14:0] mag);
    int unsigned  remaining;
    int unsigned  zeros;
    int unsigned  total;
    int unsigned  count;
    int unsigned  i;
    int           value;
    int           sum;
    int           idx;
    bit           has_value;
    bit           bad;
    coef_result_t r;
    value = 0;
    idx   = int'(comp) % NUM_COMPONENTS;
    if (blk_pos == 0) begin
      // DC term: predictor plus difference, clamped, written back
      bad = (sym > 8'd15);
      sum = int'(dc_pred[idx]) + (bad ? 0 : jpeg_extend(mag, sym));
      if (sum > COEF_HI) sum = COEF_HI;
      if (sum < COEF_LO) sum = COEF_LO;
      dc_pred[idx] = COEF_W'(sum);
      r.coef = COEF_W'(sum);
      r.pos  = '0;
      r.done = (BLOCK_COEFFS <= 1);
      r.last = 1'b1;
      r.bad  = bad;
      pending_coefs.push_back(r);
      blk_pos = 1;
      return;
    end
    remaining = BLOCK_COEFFS - blk_pos;
    if (sym == SYM_ZRL) begin
      zeros     = ZRL_LEN;
      has_value = 1'b0;
    end else if (sym == SYM_EOB) begin
      zeros     = remaining;
      has_value = 1'b0;
    end else begin
      zeros     = sym[7:4];
      has_value = 1'b1;
      value     = jpeg_extend(mag, sym[3:0]);
    end
    total = zeros + (has_value ? 1 : 0);
    bad   = (total > remaining);
    count = bad ? remaining : total;
    for (i = 0; i < count; i++) begin
      r.coef = (has_value && i == zeros) ? COEF_W'(value) : '0;
      r.pos  = POS_OUT_W'(blk_pos + i);
      r.done = (blk_pos + i + 1 == BLOCK_COEFFS);
      r.last = (i + 1 == count);
      r.bad  = bad;
      pending_coefs.push_back(r);
    end
    blk_pos = (blk_pos + count >= BLOCK_COEFFS) ? 0 : blk_pos + count;
  endfunction

  // Present one request, hold it until taken, then update the model.
  // tvalid is only dropped for a gap, so it never toggles within a step.
  task automatic send_request(logic [1:0] comp, logic [7:0] sym, logic [14:0] mag);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, mag, sym};
    s_tuser  <= comp;
    do @(posedge clk); while (!s_tready);
    decode_request(comp, sym, mag);
  endtask

  function automatic logic [7:0] random_ac_symbol();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return {4'($urandom_range(15)), 4'($urandom_range(15, 1))};
    if (pick < 80) return {4'($urandom_range(14, 1)), 4'h0};  // zeros then a zero
    if (pick < 90) return SYM_ZRL;
    return 8'($urandom);                                       // anything at all
  endfunction

  // result side: random backpressure and the scoreboard check
  always @(posedge clk) begin
    coef_result_t want;
    m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    if (!rst && m_tvalid && m_tready) begin
      if (pending_coefs.size() == 0) begin
        $error("unexpected coefficient %0d at position %0d",
               $signed(m_tdata[20:0]), m_tdata[26:21]);
        error_count++;
      end else begin
        want = pending_coefs.pop_front();
        if (m_tdata[20:0] !== want.coef) begin
          $error("coefficient: expected %0d, got %0d", want.coef, $signed(m_tdata[20:0]));
          error_count++;
        end
        if (m_tdata[26:21] !== want.pos) begin
          $error("position: expected %0d, got %0d", want.pos, m_tdata[26:21]);
          error_count++;
        end
        if (m_tdata[27] !== want.done) begin
          $error("block_done: expected %0b, got %0b", want.done, m_tdata[27]);
          error_count++;
        end
        if (m_tlast !== want.last) begin
          $error("run_last: expected %0b, got %0b", want.last, m_tlast);
          error_count++;
        end
        if (m_tuser !== want.bad) begin
          $error("bad_symbol: expected %0b, got %0b", want.bad, m_tuser);
          error_count++;
        end
      end
    end
  end

  // watchdog: nothing moving on either side for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    coef_result_t typed_res;
    int unsigned  sent;
    int unsigned  blk;
    int unsigned  n_ac;
    int unsigned  k;
    int unsigned  ending;
    logic [1:0]   comp;
    logic [7:0]   cls;
    logic [14:0]  mag;

    for (k = 0; k < NUM_COMPONENTS; k++) dc_pred[k] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (k = 0; k < N_DIRECTED; k++) begin
      send_request(directed_rows[k].comp, directed_rows[k].sym, directed_rows[k].mag);
      if (directed_rows[k].typed) begin
        typed_res      = pending_coefs.pop_back();
        typed_res.coef = COEF_W'(directed_rows[k].coef);
        typed_res.pos  = '0;
        typed_res.done = 1'b0;
        typed_res.last = 1'b1;
        typed_res.bad  = directed_rows[k].bad;
        pending_coefs.push_back(typed_res);
      end
    end

    // random blocks: DC term, a few AC terms, then a way out of the block
    sent = 0;
    blk  = 0;
    while (blk < PUSH_BLOCKS || sent < RANDOM_ITEMS) begin
      quiet = (blk >= 30 && blk < 46);
      if (blk < PUSH_BLOCKS) begin
        // full-size steps drive comp 0 to the top rail and comp 1 to the bottom
        comp = 2'(blk % 2);
        cls  = 8'h0F;
        mag  = (blk % 2 == 0) ? 15'h7FFF : 15'h0000;
      end else begin
        comp = 2'($urandom_range(3));
        cls  = ($urandom_range(99) < 85) ? 8'($urandom_range(15)) : 8'($urandom_range(255, 16));
        mag  = 15'($urandom);
      end
      send_request(comp, cls, mag);
      sent++;
      n_ac = (blk < PUSH_BLOCKS) ? 0 : $urandom_range(3);
      for (k = 0; k < n_ac && blk_pos != 0; k++) begin
        send_request(2'($urandom_range(3)), random_ac_symbol(), 15'($urandom));
        sent++;
      end
      ending = (blk < PUSH_BLOCKS) ? 0 : $urandom_range(9);
      while (blk_pos != 0) begin
        if (ending < 6) send_request(2'($urandom_range(3)), SYM_EOB, 15'($urandom));
        else if (ending < 8) send_request(2'($urandom_range(3)), SYM_ZRL, 15'($urandom));
        else send_request(2'($urandom_range(3)), random_ac_symbol(), 15'($urandom));
        sent++;
      end
      blk++;
    end

    // drain, then give a stray extra result time to show up
    s_tvalid <= 1'b0;
    quiet = 1'b1;
    while (pending_coefs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/jcrd_pkg.sv
hw/rtl/jcrd_ctrl.sv
hw/rtl/jcrd_datapath.sv
hw/rtl/jpeg_coefficient_run_decoder.sv
tb/jpeg_coefficient_run_decoder_tb.sv
